// File: hdl/stopwatch_countdown_timer_assert.svh
// Assertion macros used by the checker file.
`ifndef STOPWATCH_COUNTDOWN_TIMER_ASSERT_SVH
`define STOPWATCH_COUNTDOWN_TIMER_ASSERT_SVH

// Checked outside reset.
`define SWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/swc_pkg.sv
package swc_pkg;

  localparam int HourW   = 7;
  localparam int MinSecW = 6;
  localparam int CentiW  = 7;
  localparam int PreW    = 16;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  localparam logic [HourW-1:0]   HOUR_MAX   = 7'd99;
  localparam logic [MinSecW-1:0] MINSEC_MAX = 6'd59;
  localparam logic [CentiW-1:0]  CENTI_MAX  = 7'd99;

  localparam logic [ModeW-1:0] MODE_UP   = 2'd0;
  localparam logic [ModeW-1:0] MODE_DOWN = 2'd1;
  localparam logic [ModeW-1:0] MODE_HOLD = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_UP_LIM   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOWN_LIM = 2'd2;

  localparam logic [PreW-1:0] UP_LIM_RESET   = 16'd10;
  localparam logic [PreW-1:0] DOWN_LIM_RESET = 16'd1000;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic               func;
    logic [HourW-1:0]   load_hours;
    logic [MinSecW-1:0] load_minutes;
    logic [MinSecW-1:0] load_seconds;
    logic [CentiW-1:0]  load_centis;
  } swc_in_t;

  typedef struct packed {
    logic [HourW-1:0]   hours;
    logic [MinSecW-1:0] minutes;
    logic [MinSecW-1:0] seconds;
    logic [CentiW-1:0]  centis;
    logic               time_up;
  } swc_out_t;

  typedef struct packed {
    logic load;
    logic en;
    logic down;
  } swc_ctl_t;

  typedef struct packed {
    logic             load;
    logic             tick;
    logic [ModeW-1:0] mode;
  } swc_pre_ctl_t;

endpackage

// File: hdl/swc_prescale.sv
module swc_prescale (
  input  logic                       clk,
  input  logic                       rst,
  input  swc_pkg::swc_pre_ctl_t      ctl,
  input  logic [swc_pkg::PreW-1:0]   up_limit,
  input  logic [swc_pkg::PreW-1:0]   down_limit,
  output logic                       fire_up,
  output logic                       fire_down
);
  import swc_pkg::*;

  logic [PreW-1:0] count;
  logic [PreW-1:0] count_next;

  always_comb begin
    fire_up    = 1'b0;
    fire_down  = 1'b0;
    count_next = count;
    if (ctl.load) begin
      count_next = '0;
    end else if (ctl.tick && ctl.mode == MODE_UP) begin
      if (count > up_limit) begin
        fire_up    = 1'b1;
        count_next = '0;
      end else begin
        count_next = count + PreW'(1);
      end
    end else if (ctl.tick && ctl.mode == MODE_DOWN) begin
      if (count >= down_limit) begin
        fire_down  = 1'b1;
        count_next = '0;
      end else begin
        count_next = count + PreW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// File: hdl/swc_digit.sv
module swc_digit #(
  parameter int             W           = swc_pkg::CentiW,
  parameter logic [W-1:0]   MAX         = swc_pkg::CENTI_MAX,
  parameter logic [W-1:0]   DOWN_RELOAD = swc_pkg::CENTI_MAX
) (
  input  logic              clk,
  input  logic              rst,
  input  swc_pkg::swc_ctl_t ctl,
  input  logic [W-1:0]      load_value,
  output logic [W-1:0]      value_next,
  output logic              carry
);
  import swc_pkg::*;

  logic [W-1:0] value;

  always_comb begin
    carry      = 1'b0;
    value_next = value;
    if (ctl.load) begin
      value_next = (load_value > MAX) ? MAX : load_value;
    end else if (ctl.en && ctl.down) begin
      if (value != '0) begin
        value_next = value - W'(1);
      end else begin
        value_next = DOWN_RELOAD;
        carry      = 1'b1;
      end
    end else if (ctl.en) begin
      if (value >= MAX) begin
        value_next = '0;
        carry      = 1'b1;
      end else begin
        value_next = value + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

// File: hdl/stopwatch_countdown_timer.sv
// Stopwatch and countdown timer.
// Input channel (in_valid/in_ready/in_data) takes one word per item: a tick,
// or a load of hours, minutes, seconds and hundredths (clamped to range).
// Output channel (out_valid/out_ready/out_data) returns one word per item
// with the time and the sticky time-up flag as they stand after that item.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes mode,
// the stopwatch prescale limit and the countdown prescale limit; it is always
// ready and should be used only while no item is in flight.
// A word's result is registered and shown in the cycle after it is accepted.
// Throughput is one word per cycle while out_ready is high, set by the carry
// chain of the prescaler and the digit cells that all update together.
// The output register frees the input as soon as it is taken or empty, so a
// new word is accepted in the same cycle that the previous result leaves.
// While the receiver stalls, in_ready is low and the result is held.
// Synchronous reset clears the time, the prescaler and the flag, and sets
// stopwatch mode with limits 10 and 1000.
module stopwatch_countdown_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  swc_pkg::swc_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output swc_pkg::swc_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swc_pkg::CfgW-1:0]     cfg_data
);
  import swc_pkg::*;

  logic [ModeW-1:0] mode;
  logic [PreW-1:0]  up_limit;
  logic [PreW-1:0]  down_limit;
  logic             done;
  logic             done_next;

  logic accept;
  logic load;
  logic fire_up;
  logic fire_down;

  swc_pre_ctl_t pre_ctl;
  swc_ctl_t     centi_ctl;
  swc_ctl_t     sec_ctl;
  swc_ctl_t     min_ctl;
  swc_ctl_t     hour_ctl;

  logic [CentiW-1:0]  centi_next;
  logic [MinSecW-1:0] sec_next;
  logic [MinSecW-1:0] min_next;
  logic [HourW-1:0]   hour_next;
  logic centi_carry;
  logic sec_carry;
  logic min_carry;
  logic hour_carry;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign load      = accept && in_data.func == FUNC_LOAD;

  assign pre_ctl.load = load;
  assign pre_ctl.tick = accept && in_data.func == FUNC_TICK;
  assign pre_ctl.mode = mode;

  swc_prescale u_pre (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pre_ctl),
    .up_limit   (up_limit),
    .down_limit (down_limit),
    .fire_up    (fire_up),
    .fire_down  (fire_down)
  );

  assign centi_ctl = '{load: load, en: fire_up, down: 1'b0};
  assign sec_ctl   = '{load: load, en: centi_carry || fire_down, down: fire_down};
  assign min_ctl   = '{load: load, en: sec_carry, down: fire_down};
  assign hour_ctl  = '{load: load, en: min_carry, down: fire_down};

  swc_digit #(.W(CentiW), .MAX(CENTI_MAX), .DOWN_RELOAD(CENTI_MAX)) u_centi (
    .clk        (clk),
    .rst        (rst),
    .ctl        (centi_ctl),
    .load_value (in_data.load_centis),
    .value_next (centi_next),
    .carry      (centi_carry)
  );

  swc_digit #(.W(MinSecW), .MAX(MINSEC_MAX), .DOWN_RELOAD(MINSEC_MAX)) u_sec (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sec_ctl),
    .load_value (in_data.load_seconds),
    .value_next (sec_next),
    .carry      (sec_carry)
  );

  swc_digit #(.W(MinSecW), .MAX(MINSEC_MAX), .DOWN_RELOAD(MINSEC_MAX)) u_min (
    .clk        (clk),
    .rst        (rst),
    .ctl        (min_ctl),
    .load_value (in_data.load_minutes),
    .value_next (min_next),
    .carry      (min_carry)
  );

  // At zero hours a countdown borrow leaves hours at zero and raises the flag.
  swc_digit #(.W(HourW), .MAX(HOUR_MAX), .DOWN_RELOAD('0)) u_hour (
    .clk        (clk),
    .rst        (rst),
    .ctl        (hour_ctl),
    .load_value (in_data.load_hours),
    .value_next (hour_next),
    .carry      (hour_carry)
  );

  always_comb begin
    done_next = done;
    if (load) begin
      done_next = 1'b0;
    end else if (hour_carry && fire_down) begin
      done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_UP;
      up_limit   <= UP_LIM_RESET;
      down_limit <= DOWN_LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:     mode       <= cfg_data[ModeW-1:0];
        REG_UP_LIM:   up_limit   <= cfg_data[PreW-1:0];
        REG_DOWN_LIM: down_limit <= cfg_data[PreW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      done <= done_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.hours   <= hour_next;
      out_data.minutes <= min_next;
      out_data.seconds <= sec_next;
      out_data.centis  <= centi_next;
      out_data.time_up <= done_next;
    end
  end

endmodule

// File: hdl/swc_checker.sv
`include "stopwatch_countdown_timer_assert.svh"

module swc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input swc_pkg::swc_in_t             in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input swc_pkg::swc_out_t            out_data,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [swc_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [swc_pkg::CfgW-1:0]     cfg_data
);
  import swc_pkg::*;

  logic cfg_seen;

  assign cfg_seen = cfg_valid && cfg_ready && cfg_index == REG_MODE && cfg_data[0];

  `SWC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
  `SWC_ASSERT(a_in_result, in_valid && in_ready |=> out_valid, "accepted word produced no result")
  `SWC_ASSERT(a_range, out_valid |-> out_data.hours <= HOUR_MAX && out_data.minutes <= MINSEC_MAX && out_data.seconds <= MINSEC_MAX && out_data.centis <= CENTI_MAX, "time digit out of range")
  `SWC_ASSERT(a_load_clears, in_valid && in_ready && in_data.func == FUNC_LOAD && !cfg_seen |=> !out_data.time_up, "load did not clear time-up")
  `SWC_ASSERT_ALWAYS(a_free_input, !rst && !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind stopwatch_countdown_timer swc_checker u_swc_checker (.*);

// File: tb/sv/tb.sv
module tb;
  import swc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam logic [ModeW-1:0] MODE_UNDEF = 2'd3;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int RANDOM_WORDS = 490;

  typedef struct {
    bit                  is_reg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgW-1:0]     data;
    swc_in_t             word;
    bit                  pin;
    swc_out_t            want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  swc_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  swc_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  logic [ModeW-1:0]   cur_mode = MODE_UP;
  logic [PreW-1:0]    up_lim = UP_LIM_RESET;
  logic [PreW-1:0]    down_lim = DOWN_LIM_RESET;
  logic [PreW-1:0]    prescale = '0;
  logic [HourW-1:0]   hrs = '0;
  logic [MinSecW-1:0] mins = '0;
  logic [MinSecW-1:0] secs = '0;
  logic [CentiW-1:0]  cents = '0;
  logic               up_flag = 1'b0;

  swc_out_t pending_times[$];
  row_t     plan[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       accepted_words = 0;
  int       returned_words = 0;
  int       send_idle = 0;
  int       recv_stall = 0;
  logic     pin_next = 1'b0;
  swc_out_t pin_want = '0;

  stopwatch_countdown_timer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic swc_out_t next_reading(swc_in_t w);
    if (w.func == FUNC_LOAD) begin
      hrs = (w.load_hours > HOUR_MAX) ? HOUR_MAX : w.load_hours;
      mins = (w.load_minutes > MINSEC_MAX) ? MINSEC_MAX : w.load_minutes;
      secs = (w.load_seconds > MINSEC_MAX) ? MINSEC_MAX : w.load_seconds;
      cents = (w.load_centis > CENTI_MAX) ? CENTI_MAX : w.load_centis;
      prescale = '0;
      up_flag = 1'b0;
    end else if (cur_mode == MODE_UP) begin
      if (prescale > up_lim) begin
        prescale = '0;
        if (cents < CENTI_MAX) begin
          cents = cents + 1'b1;
        end else begin
          cents = '0;
          if (secs < MINSEC_MAX) begin
            secs = secs + 1'b1;
          end else begin
            secs = '0;
            if (mins < MINSEC_MAX) begin
              mins = mins + 1'b1;
            end else begin
              mins = '0;
              hrs = (hrs >= HOUR_MAX) ? '0 : hrs + 1'b1;
            end
          end
        end
      end else begin
        prescale = prescale + 1'b1;
      end
    end else if (cur_mode == MODE_DOWN) begin
      if (prescale >= down_lim) begin
        prescale = '0;
        if (secs != 0) begin
          secs = secs - 1'b1;
        end else begin
          secs = MINSEC_MAX;
          if (mins != 0) begin
            mins = mins - 1'b1;
          end else begin
            mins = MINSEC_MAX;
            if (hrs != 0) begin
              hrs = hrs - 1'b1;
            end else begin
              up_flag = 1'b1;
            end
          end
        end
      end else begin
        prescale = prescale + 1'b1;
      end
    end
    return '{hours: hrs, minutes: mins, seconds: secs, centis: cents, time_up: up_flag};
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    swc_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        returned_words++;
        if (pending_times.size() == 0) begin
          mismatches++;
          $display("%0t: word %p arrived with nothing pending", $time, out_data);
        end else begin
          want = pending_times.pop_front();
          check_field("hours", want.hours, out_data.hours);
          check_field("minutes", want.minutes, out_data.minutes);
          check_field("seconds", want.seconds, out_data.seconds);
          check_field("centis", want.centis, out_data.centis);
          check_field("time_up", want.time_up, out_data.time_up);
        end
      end
      if (in_valid && in_ready) begin
        want = next_reading(in_data);
        pending_times.push_back(pin_next ? pin_want : want);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (returned_words != accepted_words) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE: cur_mode = d[ModeW-1:0];
      REG_UP_LIM: up_lim = d;
      REG_DOWN_LIM: down_lim = d;
      default: ;
    endcase
  endtask

  task automatic send_word(swc_in_t w, bit pin, swc_out_t want);
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    pin_next <= pin;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
    accepted_words++;
  endtask

  function automatic swc_in_t any_word();
    return swc_in_t'($urandom);
  endfunction

  function automatic swc_in_t tick_word();
    swc_in_t w;
    w = any_word();
    w.func = FUNC_TICK;
    return w;
  endfunction

  // Loads that sit next to a rollover, so a short run of ticks crosses it.
  function automatic swc_in_t near_word(bit up);
    swc_in_t w;
    w = any_word();
    w.func = FUNC_LOAD;
    if (up) begin
      if ($urandom_range(0, 2) != 0) w.load_hours = HOUR_MAX - HourW'($urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) w.load_minutes = MINSEC_MAX;
      if ($urandom_range(0, 2) != 0) w.load_seconds = MINSEC_MAX;
      if ($urandom_range(0, 2) != 0) w.load_centis = CENTI_MAX - CentiW'($urandom_range(0, 3));
    end else begin
      if ($urandom_range(0, 2) != 0) w.load_hours = HourW'($urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) w.load_minutes = MinSecW'($urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) w.load_seconds = MinSecW'($urandom_range(0, 2));
    end
    return w;
  endfunction

  function automatic logic [CfgW-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CfgW'($urandom);
      default: return CfgW'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic row_t word_row(logic fn, int h, int m, int s, int c);
    row_t r;
    r.is_reg = 1'b0;
    r.idx = '0;
    r.data = '0;
    r.pin = 1'b0;
    r.want = '0;
    r.word.func = fn;
    r.word.load_hours = HourW'(h);
    r.word.load_minutes = MinSecW'(m);
    r.word.load_seconds = MinSecW'(s);
    r.word.load_centis = CentiW'(c);
    return r;
  endfunction

  function automatic row_t pinned(row_t r, int h, int m, int s, int c, logic up);
    r.pin = 1'b1;
    r.want.hours = HourW'(h);
    r.want.minutes = MinSecW'(m);
    r.want.seconds = MinSecW'(s);
    r.want.centis = CentiW'(c);
    r.want.time_up = up;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
    row_t r;
    r = word_row(FUNC_TICK, 0, 0, 0, 0);
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  task automatic random_phase();
    int sent;
    int pick;
    logic [ModeW-1:0] m;
    logic [CfgW-1:0] d;
    swc_in_t w;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      pick = $urandom_range(0, 19);
      m = (pick < 9) ? MODE_UP : (pick < 17) ? MODE_DOWN : (pick < 19) ? MODE_HOLD : MODE_UNDEF;
      d = CfgW'($urandom);
      d[ModeW-1:0] = m;
      set_reg(REG_MODE, d);
      if ($urandom_range(0, 1) != 0) set_reg(REG_UP_LIM, pick_limit());
      if ($urandom_range(0, 1) != 0) set_reg(REG_DOWN_LIM, pick_limit());
      if ((m == MODE_UP || m == MODE_DOWN) && $urandom_range(0, 6) != 0) begin
        send_word(near_word(m == MODE_UP), 1'b0, '0);
        sent++;
        repeat ($urandom_range(5, 40)) begin
          w = ($urandom_range(0, 19) == 0) ? any_word() : tick_word();
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(3, 15)) begin
          send_word(any_word(), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 80, 0, 24};
    stall_set = '{0, 0, 80, 24};

    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 0, 0, 0, 0, 1'b0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 127, 63, 63, 127), 99, 59, 59, 99, 1'b0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 0, 0, 0, 0), 0, 0, 0, 0, 1'b0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 99, 59, 59, 99), 99, 59, 59, 99, 1'b0));
    plan.push_back(reg_row(REG_UP_LIM, '0));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 99, 59, 59, 99, 1'b0));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 0, 0, 0, 0, 1'b0));
    plan.push_back(word_row(FUNC_TICK, 127, 63, 63, 127));
    plan.push_back(word_row(FUNC_TICK, 0, 0, 0, 0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 100, 60, 60, 100), 99, 59, 59, 99, 1'b0));
    plan.push_back(reg_row(REG_MODE, CfgW'(MODE_HOLD)));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 99, 59, 59, 99, 1'b0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 1, 2, 3, 4), 1, 2, 3, 4, 1'b0));
    plan.push_back(reg_row(REG_MODE, CfgW'(MODE_UNDEF)));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 1, 2, 3, 4, 1'b0));
    plan.push_back(reg_row(REG_MODE, CfgW'(MODE_DOWN)));
    plan.push_back(reg_row(REG_DOWN_LIM, '0));
    plan.push_back(pinned(word_row(FUNC_LOAD, 0, 0, 1, 50), 0, 0, 1, 50, 1'b0));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 0, 0, 0, 50, 1'b0));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 0, 59, 59, 50, 1'b1));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 0, 59, 58, 50, 1'b1));
    plan.push_back(pinned(word_row(FUNC_LOAD, 5, 0, 0, 7), 5, 0, 0, 7, 1'b0));
    plan.push_back(pinned(word_row(FUNC_TICK, 0, 0, 0, 0), 4, 59, 59, 7, 1'b0));
    plan.push_back(reg_row(REG_DOWN_LIM, '1));
    plan.push_back(word_row(FUNC_TICK, 0, 0, 0, 0));
    plan.push_back(reg_row(REG_UNUSED, '1));
    plan.push_back(word_row(FUNC_TICK, 0, 0, 0, 0));
    plan.push_back(reg_row(REG_UP_LIM, '1));
    plan.push_back(reg_row(REG_MODE, CfgW'(MODE_UP)));
    plan.push_back(word_row(FUNC_TICK, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) drain();
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].word, plan[i].pin, plan[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_set[p];
      recv_stall = stall_set[p];
      random_phase();
    end

    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
